/* sv/dvc_pkg.sv */
package dvc_pkg;

  localparam int VALUE_W           = 32;
  localparam int COUNT_W           = 5;
  localparam int DEFAULT_MAX_ITEMS = 16;

  // Request travelling down the cell chain
  typedef struct packed {
    logic               valid;   // slot carries a request
    logic               active;  // value was taken into the set (not dropped)
    logic               last;    // closes the set
    logic               ovf;     // set overflowed (meaningful with last)
    logic               seen;    // an earlier cell already holds this value
    logic               placed;  // a cell took this value as a new distinct one
    logic [VALUE_W-1:0] value;
  } dvc_token_t;

endpackage

/* sv/dvc_cell.sv */
module dvc_cell
  import dvc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  dvc_token_t tok_in,
  output dvc_token_t tok_out
);

  logic               occupied;
  logic [VALUE_W-1:0] stored;
  logic               hit;
  logic               take;
  dvc_token_t         tok_mod;

  always_comb begin
    hit  = tok_in.valid && tok_in.active && occupied && (stored == tok_in.value);
    take = tok_in.valid && tok_in.active && !occupied && !tok_in.seen && !tok_in.placed;
    tok_mod        = tok_in;
    tok_mod.seen   = tok_in.seen | hit;
    tok_mod.placed = tok_in.placed | take;
  end

  // Free the cell once the closing request has gone by
  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= 1'b0;
    end else if (adv) begin
      if (tok_in.valid && tok_in.last) begin
        occupied <= 1'b0;
      end else if (take) begin
        occupied <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && take) begin
      stored <= tok_in.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (adv) begin
      tok_out <= tok_mod;
    end
  end

endmodule

/* sv/dvc_tally.sv */
module dvc_tally
  import dvc_pkg::*;
#(
  parameter int MAX_ITEMS = DEFAULT_MAX_ITEMS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  dvc_token_t         tok_in,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [COUNT_W-1:0] out_count,
  output logic               out_ovf
);

  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic [CW+4:0]    count_ext;
  logic             fire;

  always_comb begin
    count_next = count + CW'(tok_in.placed);
    count_ext  = {5'b0, count_next};
    fire       = adv && tok_in.valid && tok_in.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (adv && tok_in.valid) begin
      count <= tok_in.last ? '0 : count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // A single distinct value reports as zero
  always_ff @(posedge clk) begin
    if (fire) begin
      out_count <= (count_next == CW'(1)) ? '0 : count_ext[COUNT_W-1:0];
      out_ovf   <= tok_in.ovf;
    end
  end

endmodule

/* sv/distinct_value_counter.sv */
// Channel  | Signals                                    | Direction
// ---------+--------------------------------------------+----------
// sample   | sample_valid, sample_stall, sample_value,  | in
//          | last_item                                  |
// result   | result_valid, result_stall,                | out
//          | distinct_count, overflow                   |
//
// While sample_stall is low, one request enters per cycle and the chain of MAX_ITEMS
// cells moves one cell a cycle. The tally registers the result behind the last cell.
// The closing request frees each cell as it passes: no clearing pass after reset.
// A stalled result holds the whole chain, so sample_stall follows result_stall
// while a result is pending.
module distinct_value_counter
  import dvc_pkg::*;
#(
  parameter int MAX_ITEMS = DEFAULT_MAX_ITEMS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      sample_valid,
  output logic                      sample_stall,
  input  logic signed [VALUE_W-1:0] sample_value,
  input  logic                      last_item,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic [COUNT_W-1:0]        distinct_count,
  output logic                      overflow
);

  localparam int            CW      = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

  // Intake: number of stored values and drop flag of the open set
  logic [CW-1:0] item_count;
  logic          overflow_seen;
  logic          adv;
  logic          accept;
  logic          room;
  dvc_token_t    link [MAX_ITEMS+1];

  // Advance the chain whenever the result register can take what exits
  assign adv          = !result_valid || !result_stall;
  assign sample_stall = !adv;
  assign accept       = sample_valid && adv;
  assign room         = item_count < MAX_CNT;

  // Build the request at the head of the chain; a dropped value goes inert
  always_comb begin
    link[0].valid  = sample_valid;
    link[0].active = room;
    link[0].last   = last_item;
    link[0].ovf    = overflow_seen || !room;
    link[0].seen   = 1'b0;
    link[0].placed = 1'b0;
    link[0].value  = sample_value;
  end

  // Count stored values, note drops, restart on the closing request
  always_ff @(posedge clk) begin
    if (rst) begin
      item_count    <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      if (last_item) begin
        item_count    <= '0;
        overflow_seen <= 1'b0;
      end else if (room) begin
        item_count    <= item_count + CW'(1);
      end else begin
        overflow_seen <= 1'b1;
      end
    end
  end

  // Chain of compare-and-hold cells: each keeps one distinct value of the set
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    dvc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .tok_in  (link[i]),
      .tok_out (link[i+1])
    );
  end

  // Count new values leaving the chain and register the result
  dvc_tally #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_tally (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .tok_in    (link[MAX_ITEMS]),
    .out_stall (result_stall),
    .out_valid (result_valid),
    .out_count (distinct_count),
    .out_ovf   (overflow)
  );

  a_no_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> distinct_count != COUNT_W'(1))
    else $error("single distinct value reported as one");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    item_count <= MAX_CNT)
    else $error("item count beyond capacity");

  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    sample_stall == (result_valid && result_stall))
    else $error("input stall out of step with result stall");

  a_drop_flag: assert property (@(posedge clk) disable iff (rst)
    (accept && !room && !last_item) |=> overflow_seen)
    else $error("dropped value not flagged");

endmodule
